[sv/sfe_pkg.sv]
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants for the stereo feedback echo.
// ----------------------------------------------------------------------------
package sfe_pkg;

    // One audio sample, Q1.15 two's complement.
    localparam int SAMPLE_W = 16;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // A Q0.16 fraction that can also hold exactly 1.0.
    localparam int COEF_W = 17;
    typedef logic [COEF_W-1:0] coef_t;

    // Unity gain in Q0.16 and the feedback ceiling of 0.95.
    localparam coef_t UNITY = 17'd65536;
    localparam logic [15:0] FEEDBACK_LIMIT = 16'd62259;

    // Register stages from lane operands to lane result.
    localparam int LANE_LATENCY = 6;

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_ENABLE   = 2'd0;
    localparam cfg_index_t CFG_DELAY    = 2'd1;
    localparam cfg_index_t CFG_FEEDBACK = 2'd2;
    localparam cfg_index_t CFG_MIX      = 2'd3;

endpackage

[sv/sfe_ram.sv]
// ----------------------------------------------------------------------------
// sfe_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/sfe_clip_lane.sv]
// ----------------------------------------------------------------------------
// sfe_clip_lane
// One mixing and soft-clip lane: forms s*s_coef + d*d_coef with 1.0 = 2^31,
// applies x - x^3/3 with saturation at magnitude one, and scales to a
// 16-bit sample truncated toward zero. Six register stages.
// ----------------------------------------------------------------------------
module sfe_clip_lane
    import sfe_pkg::*;
(
    input  logic    clk,
    input  sample_t s,
    input  coef_t   s_coef,
    input  sample_t d,
    input  coef_t   d_coef,
    output sample_t result
);

    // Reciprocal of three for an exact floor division of a 32-bit value.
    localparam logic [63:0] RECIP3 = 64'h0000_0000_AAAA_AAAB;
    localparam logic [33:0] MAG_ONE = 34'h0_8000_0000;

    logic signed [33:0] ps_next, pd_next, ps_reg, pd_reg;
    logic signed [33:0] sum;
    logic [33:0]        mag;
    logic               neg2_reg, big2_reg;
    logic [31:0]        m2_in_reg;
    logic [63:0]        sq;
    logic [31:0]        m2_next, m2_reg, m3_m_reg;
    logic               neg3_reg, big3_reg;
    logic [63:0]        cube;
    logic [31:0]        m3_next, m3_reg, m4_m_reg;
    logic               neg4_reg, big4_reg;
    logic [63:0]        quot;
    logic [31:0]        q_next, q_reg, m5_m_reg;
    logic               neg5_reg, big5_reg;
    logic [31:0]        y;
    logic [46:0]        scaled;
    logic [15:0]        r;
    sample_t            result_next, result_reg;

    // Stage 1: the two weighted products.
    assign ps_next = 34'(s) * 34'($signed({1'b0, s_coef}));
    assign pd_next = 34'(d) * 34'($signed({1'b0, d_coef}));

    // Stage 2: sum, sign and magnitude, overflow of the clip range.
    assign sum = ps_reg + pd_reg;
    assign mag = sum[33] ? 34'(-sum) : 34'(sum);

    // Stage 3: square of the magnitude.
    assign sq      = 64'(m2_in_reg) * 64'(m2_in_reg);
    assign m2_next = sq[62:31];

    // Stage 4: cube of the magnitude.
    assign cube    = 64'(m2_reg) * 64'(m3_m_reg);
    assign m3_next = cube[62:31];

    // Stage 5: divide the cube by three.
    assign quot   = 64'(m3_reg) * RECIP3;
    assign q_next = 32'(quot[63:33]);

    // Stage 6: x - x^3/3, scale by 32767, restore the sign.
    assign y      = m5_m_reg - q_reg;
    assign scaled = {y, 15'b0} - 47'(y);
    assign r      = big5_reg ? 16'd32767 : scaled[46:31];
    assign result_next = neg5_reg ? sample_t'(-$signed(r)) : sample_t'(r);

    always_ff @(posedge clk)
    begin
        ps_reg     <= ps_next;
        pd_reg     <= pd_next;
        neg2_reg   <= sum[33];
        big2_reg   <= (mag > MAG_ONE);
        m2_in_reg  <= mag[31:0];
        m2_reg     <= m2_next;
        m3_m_reg   <= m2_in_reg;
        neg3_reg   <= neg2_reg;
        big3_reg   <= big2_reg;
        m3_reg     <= m3_next;
        m4_m_reg   <= m3_m_reg;
        neg4_reg   <= neg3_reg;
        big4_reg   <= big3_reg;
        q_reg      <= q_next;
        m5_m_reg   <= m4_m_reg;
        neg5_reg   <= neg4_reg;
        big5_reg   <= big4_reg;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

[sv/stereo_feedback_echo_top.sv]
// ----------------------------------------------------------------------------
// stereo_feedback_echo_top
// Stereo feedback echo with a delay ring of RING_FRAMES frames.
// ----------------------------------------------------------------------------
// An echo item is accepted, its delayed frame is read from the ring RAM in
// the next cycle, and four clip lanes (feedback and output path for each
// channel) work on it in parallel for six register stages; the result is
// loaded into the output register once the lanes are through and the
// output register is free, and only then does the block return to idle and
// accept the next item. Pass-through items (effect disabled, delay zero or
// beyond the ring) bypass the lanes. A finished result waits in the output
// register while the next item is taken in. The ring needs no clearing
// pass: the block tracks how far it has been filled since reset, and a
// frame that was never written reads as silence.
// ----------------------------------------------------------------------------
module stereo_feedback_echo_top
    import sfe_pkg::*;
#(
    parameter int RING_FRAMES = 65536
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_stall,
    input  sample_t    left_in,
    input  sample_t    right_in,
    output logic       result_valid,
    input  logic       result_stall,
    output sample_t    left_out,
    output sample_t    right_out,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  coef_t      cfg_data
);

    localparam int AW = $clog2(RING_FRAMES);
    localparam int CW = (((AW + 1) > COEF_W) ? (AW + 1) : COEF_W) + 1;
    localparam int CNT_W = $clog2(LANE_LATENCY + 1);
    localparam logic [CW-1:0] RING_W = CW'(RING_FRAMES);

    typedef enum logic {ST_IDLE, ST_WORK} state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             bypass_reg, rd_valid_reg, wrapped_reg, result_valid_reg;
    logic [AW-1:0]    wp_reg;
    sample_t          s_left_reg, s_right_reg, left_out_reg, right_out_reg;

    logic             enabled_reg;
    coef_t            delay_reg, mix_reg;
    logic [15:0]      gain_reg;

    logic             accept, out_free, done, commit, bypass_now;
    logic [CW-1:0]    rd_sum, rd_wrap;
    logic [AW-1:0]    rd_addr;
    logic [31:0]      rd_data;
    coef_t            gain_sat, mix_sat, dry;
    sample_t          d_left, d_right;
    sample_t          fb_left, fb_right, wet_left, wet_right;

    // Configuration registers; the port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            delay_reg   <= 17'd6000;
            gain_reg    <= 16'd32768;
            mix_reg     <= 17'd32768;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ENABLE:   enabled_reg <= cfg_data[0];
                CFG_DELAY:    delay_reg   <= cfg_data;
                CFG_FEEDBACK: gain_reg    <= cfg_data[15:0];
                CFG_MIX:      mix_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Saturated coefficients.
    assign gain_sat = (gain_reg > FEEDBACK_LIMIT) ? 17'(FEEDBACK_LIMIT) : 17'(gain_reg);
    assign mix_sat  = (mix_reg > UNITY) ? UNITY : mix_reg;
    assign dry      = UNITY - mix_sat;

    // Read address of the delayed frame, modulo the ring length.
    assign rd_sum  = CW'(wp_reg) + RING_W - CW'(delay_reg);
    assign rd_wrap = (rd_sum >= RING_W) ? (rd_sum - RING_W) : rd_sum;
    assign rd_addr = rd_wrap[AW-1:0];

    assign bypass_now = !enabled_reg || (delay_reg == '0) || (CW'(delay_reg) > RING_W);

    // Handshake and sequencing conditions.
    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign done         = (state_reg == ST_WORK) && out_free &&
                          (bypass_reg || (cnt_reg == CNT_W'(LANE_LATENCY)));
    assign commit       = done && !bypass_reg;

    // Delay ring.
    sfe_ram #(
        .WIDTH (32),
        .DEPTH (RING_FRAMES)
    ) u_ring (
        .clk     (clk),
        .wr_en   (commit),
        .wr_addr (wp_reg),
        .wr_data ({fb_right, fb_left}),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Frames not yet written since reset read as silence.
    assign d_left  = rd_valid_reg ? sample_t'(rd_data[15:0])  : '0;
    assign d_right = rd_valid_reg ? sample_t'(rd_data[31:16]) : '0;

    // Four clip lanes: feedback and output path for each channel.
    sfe_clip_lane u_fb_left (
        .clk    (clk),
        .s      (s_left_reg),
        .s_coef (UNITY),
        .d      (d_left),
        .d_coef (gain_sat),
        .result (fb_left)
    );

    sfe_clip_lane u_wet_left (
        .clk    (clk),
        .s      (s_left_reg),
        .s_coef (dry),
        .d      (d_left),
        .d_coef (mix_sat),
        .result (wet_left)
    );

    sfe_clip_lane u_fb_right (
        .clk    (clk),
        .s      (s_right_reg),
        .s_coef (UNITY),
        .d      (d_right),
        .d_coef (gain_sat),
        .result (fb_right)
    );

    sfe_clip_lane u_wet_right (
        .clk    (clk),
        .s      (s_right_reg),
        .s_coef (dry),
        .d      (d_right),
        .d_coef (mix_sat),
        .result (wet_right)
    );

    // Sequencer, write pointer, and the merging output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            bypass_reg       <= 1'b0;
            rd_valid_reg     <= 1'b0;
            wrapped_reg      <= 1'b0;
            wp_reg           <= '0;
            result_valid_reg <= 1'b0;
            s_left_reg       <= '0;
            s_right_reg      <= '0;
            left_out_reg     <= '0;
            right_out_reg    <= '0;
        end
        else
        begin
            // A new result takes the output register; a taken one leaves it.
            if (done)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        s_left_reg   <= left_in;
                        s_right_reg  <= right_in;
                        bypass_reg   <= bypass_now;
                        rd_valid_reg <= wrapped_reg || (rd_addr < wp_reg);
                        cnt_reg      <= '0;
                        state_reg    <= ST_WORK;
                    end
                end
                ST_WORK:
                begin
                    if (done)
                    begin
                        left_out_reg     <= bypass_reg ? s_left_reg  : wet_left;
                        right_out_reg    <= bypass_reg ? s_right_reg : wet_right;
                        state_reg        <= ST_IDLE;
                        if (commit)
                        begin
                            if (wp_reg == AW'(RING_FRAMES - 1))
                            begin
                                wp_reg      <= '0;
                                wrapped_reg <= 1'b1;
                            end
                            else
                            begin
                                wp_reg <= wp_reg + AW'(1);
                            end
                        end
                    end
                    else if (cnt_reg != CNT_W'(LANE_LATENCY))
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign left_out     = left_out_reg;
    assign right_out    = right_out_reg;

endmodule

[dv/stereo_feedback_echo_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_feedback_echo_top_tb
// Self-checking bench for the stereo feedback echo.
// ----------------------------------------------------------------------------
// A driver presents queued stereo frames and a monitor checks every processed
// frame against an in-bench echo predictor that keeps its own delay ring and
// register copy. A directed opening walks the sample extremes and the
// register corner cases. Random phases with fresh register settings follow,
// with random sender gaps and receiver stalls, and a final phase without any.
// ----------------------------------------------------------------------------
module stereo_feedback_echo_top_tb
    import sfe_pkg::*;
();

    localparam int RING       = 65536;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    hold;
    } frame_item_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } frame_out_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       sample_valid = 1'b0;
    logic       sample_stall;
    sample_t    left_in = '0;
    sample_t    right_in = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    sample_t    left_out;
    sample_t    right_out;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = CFG_ENABLE;
    coef_t      cfg_data = '0;

    // Frames waiting to be sent and processed frames still to arrive.
    frame_item_t frames_to_send[$];
    frame_out_t  echo_due[$];

    // Echo predictor state and register copy.
    bit [31:0]   model_ring [RING];
    int          model_wp = 0;
    logic        model_on = 1'b0;
    logic [16:0] model_delay = 17'd6000;
    logic [15:0] model_gain = 16'd32768;
    logic [16:0] model_mix = 17'd32768;

    int          frames_loaded = 0;
    int          frames_sent = 0;
    int          results_seen = 0;
    int          reg_writes = 0;
    int          errors = 0;
    int          idle_cycles = 0;
    int          idle_rate = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    frame_item_t next_frame;
    frame_out_t  predicted;
    frame_out_t  due_frame;
    logic        busy;

    stereo_feedback_echo_top #(
        .RING_FRAMES(RING)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .left_in     (left_in),
        .right_in    (right_in),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .left_out    (left_out),
        .right_out   (right_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Soft clip of an argument scaled so that 1.0 is 2^31, truncated to a sample.
    function automatic sample_t clip_sample(input longint arg);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] m2;
        logic [63:0] m3;
        logic [63:0] y;
        logic [63:0] r;
        neg = (arg < 0);
        mag = neg ? -arg : arg;
        if (mag > 64'h8000_0000)
        begin
            r = 64'd32767;
        end
        else
        begin
            m2 = (mag * mag) >> 31;
            m3 = (m2 * mag) >> 31;
            y  = mag - m3 / 3;
            r  = (y * 64'd32767) >> 31;
        end
        return neg ? sample_t'(-r[15:0]) : sample_t'(r[15:0]);
    endfunction

    // Process one frame through the echo and, unless it passes through, advance the predictor's ring.
    task automatic predict_echo(input sample_t l, input sample_t r, output frame_out_t res);
        longint  gain_q;
        longint  mix_q;
        longint  dry_q;
        longint  s_l;
        longint  s_r;
        longint  d_l;
        longint  d_r;
        int      rd;
        sample_t fb_l;
        sample_t fb_r;
        if (!model_on || model_delay == 0 || model_delay > RING)
        begin
            res.left  = l;
            res.right = r;
            return;
        end
        gain_q = (model_gain > FEEDBACK_LIMIT) ? FEEDBACK_LIMIT : model_gain;
        mix_q  = (model_mix > UNITY) ? UNITY : model_mix;
        dry_q  = longint'(UNITY) - mix_q;
        rd     = (model_wp + RING - int'(model_delay)) % RING;
        s_l    = l;
        s_r    = r;
        d_l    = sample_t'(model_ring[rd][15:0]);
        d_r    = sample_t'(model_ring[rd][31:16]);
        fb_l   = clip_sample(s_l * 65536 + d_l * gain_q);
        fb_r   = clip_sample(s_r * 65536 + d_r * gain_q);
        res.left  = clip_sample(s_l * dry_q + d_l * mix_q);
        res.right = clip_sample(s_r * dry_q + d_r * mix_q);
        model_ring[model_wp] = {fb_r, fb_l};
        model_wp = (model_wp + 1) % RING;
    endtask

    // Monitor: register writes, accepted frames, checked results, watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            busy = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                busy = 1'b1;
                reg_writes++;
                case (cfg_index)
                    CFG_ENABLE:   model_on = cfg_data[0];
                    CFG_DELAY:    model_delay = cfg_data;
                    CFG_FEEDBACK: model_gain = cfg_data[15:0];
                    CFG_MIX:      model_mix = cfg_data;
                    default:      ;
                endcase
            end
            if (sample_valid && !sample_stall)
            begin
                busy = 1'b1;
                predict_echo(left_in, right_in, predicted);
                echo_due.push_back(predicted);
                frames_sent++;
            end
            if (result_valid && !result_stall)
            begin
                busy = 1'b1;
                results_seen++;
                if (echo_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected no item, got left=%0d right=%0d", $time,
                             left_out, right_out);
                end
                else
                begin
                    due_frame = echo_due.pop_front();
                    if (left_out !== due_frame.left)
                    begin
                        errors++;
                        $display("%0t: left_out expected %0d got %0d", $time,
                                 due_frame.left, left_out);
                    end
                    if (right_out !== due_frame.right)
                    begin
                        errors++;
                        $display("%0t: right_out expected %0d got %0d", $time,
                                 due_frame.right, right_out);
                    end
                end
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Driver: present the next queued frame, with random gaps between items.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else if (sample_valid && frames_loaded != frames_sent)
        begin
            // Stalled: hold the item as it is.
        end
        else if (send_gap > 0)
        begin
            send_gap = send_gap - 1;
            sample_valid <= 1'b0;
        end
        else if (frames_to_send.size() == 0 ||
                 (frames_to_send[0].hold && echo_due.size() != 0))
        begin
            sample_valid <= 1'b0;
        end
        else if (idle_rate != 0 && $urandom_range(0, 15) < idle_rate)
        begin
            send_gap = $urandom_range(0, 2);
            sample_valid <= 1'b0;
        end
        else
        begin
            next_frame = frames_to_send.pop_front();
            left_in  <= next_frame.left;
            right_in <= next_frame.right;
            sample_valid <= 1'b1;
            frames_loaded++;
        end
    end

    // Receiver stalls in random bursts.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (idle_rate != 0 && $urandom_range(0, 15) < idle_rate)
        begin
            stall_left = $urandom_range(0, 2);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    task automatic push_frame(input sample_t l, input sample_t r, input logic hold = 1'b0);
        frame_item_t f;
        f.left  = l;
        f.right = r;
        f.hold  = hold;
        frames_to_send.push_back(f);
    endtask

    // Wait until every queued frame is sent and every result is back.
    task automatic drain();
        while (frames_to_send.size() != 0 || frames_loaded != frames_sent ||
               echo_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LANE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input coef_t val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
    endtask

    // Drain the block, then write all four registers.
    task automatic set_echo(input logic on, input coef_t delay, input coef_t fb,
                            input coef_t mix);
        drain();
        write_reg(CFG_ENABLE, coef_t'(on));
        write_reg(CFG_DELAY, delay);
        write_reg(CFG_FEEDBACK, fb);
        write_reg(CFG_MIX, mix);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic sample_t pick_sample();
        sample_t v;
        case ($urandom_range(0, 9))
            0:       v = -16'sd32768;
            1:       v = 16'sd32767;
            2:       v = sample_t'($urandom_range(0, 255) - 128);
            3, 4:
            begin
                v = sample_t'($urandom_range(24000, 32767));
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = sample_t'($urandom());
        endcase
        return v;
    endfunction

    // One random phase: fresh register settings and a run of random frames.
    task automatic random_phase(input int n_items, input int rate);
        logic  on;
        coef_t delay;
        coef_t fb;
        coef_t mix;
        on = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: delay = coef_t'($urandom_range(1, 48));
            5:             delay = coef_t'($urandom_range(49, 3000));
            6:             delay = coef_t'($urandom_range(1, RING));
            7:             delay = coef_t'(RING);
            8:             delay = $urandom_range(0, 1) ? '0
                                   : coef_t'($urandom_range(RING + 1, 131071));
            default:       delay = coef_t'($urandom_range(1, 8));
        endcase
        fb  = ($urandom_range(0, 3) == 0) ? coef_t'($urandom_range(0, 65535))
                                          : coef_t'($urandom_range(20000, 62259));
        mix = ($urandom_range(0, 3) == 0) ? coef_t'($urandom_range(0, 131071))
                                          : coef_t'($urandom_range(0, 65536));
        set_echo(on, delay, fb, mix);
        idle_rate = rate;
        for (int i = 0; i < n_items; i++)
        begin
            push_frame(pick_sample(), pick_sample(), i == n_items / 3);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings leave the effect off: frames pass through.
        idle_rate = 4;
        push_frame(-16'sd32768, 16'sd32767);
        push_frame(16'sd32767, -16'sd32768);
        push_frame(16'sd0, -16'sd1);
        push_frame(16'sd1, 16'sd0);

        // One-frame delay at the feedback ceiling, fully wet.
        set_echo(1'b1, 17'd1, 17'd62259, UNITY);
        push_frame(16'sd32767, -16'sd32768);
        push_frame(16'sd32767, -16'sd32768);
        push_frame(16'sd0, 16'sd0);
        push_frame(-16'sd1, 16'sd1);
        push_frame(16'sd16384, -16'sd16384);

        // Feedback and mix written above their limits saturate.
        set_echo(1'b1, 17'd2, 17'd65535, 17'd131071);
        push_frame(16'sd32767, 16'sd32767);
        push_frame(-16'sd32768, -16'sd32768);
        push_frame(16'sd0, 16'sd0);
        push_frame(16'sd0, 16'sd0);

        // Delay of zero and delays beyond the ring pass frames through.
        set_echo(1'b1, 17'd0, 17'd32768, 17'd32768);
        push_frame(-16'sd32768, 16'sd12345);
        set_echo(1'b1, coef_t'(RING + 1), 17'd32768, 17'd32768);
        push_frame(16'sd32767, -16'sd32768);
        set_echo(1'b1, 17'd131071, 17'd32768, 17'd32768);
        push_frame(-16'sd32768, 16'sd1);

        // Delay equal to the ring, no feedback, fully dry.
        set_echo(1'b1, coef_t'(RING), 17'd0, 17'd0);
        push_frame(-16'sd32768, 16'sd32767);
        push_frame(16'sd100, -16'sd100);

        // Mid settings, with a pause until the block has emptied.
        set_echo(1'b1, 17'd3, 17'd32768, 17'd32768);
        push_frame(-16'sd32768, -16'sd32768);
        push_frame(16'sd20000, -16'sd20000, 1'b1);
        push_frame(16'sd32767, 16'sd32767);

        // Disabled with non-default settings.
        set_echo(1'b0, 17'd3, 17'd62259, UNITY);
        push_frame(-16'sd32768, 16'sd32767);

        for (int p = 0; p < 8; p++)
        begin
            random_phase(215, $urandom_range(0, 6));
        end
        // Last part runs with no idling on either side.
        random_phase(215, 0);

        drain();
        $display("Sent %0d frames and checked %0d results over %0d register writes,",
                 frames_sent, results_seen, reg_writes);
        $display("covering pass-through, ring-length delays and saturated settings.");
        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
